### rtl/assert_macros.svh
// Assertion helpers for the word machine checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define FCWM_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word machine check failed");

// Next-cycle implication, muted while reset is asserted.
`define FCWM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word machine check failed");

`endif

### rtl/fcwm_pkg.sv
`timescale 1ns / 1ps
package fcwm_pkg;

    localparam int MEM_WORDS_DEF   = 100;
    localparam int BLOCK_WORDS_DEF = 10;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;
    localparam int CC_W   = 4;
    localparam int OP_W   = 3;
    localparam int RAW_W  = 12;
    localparam int STEP_W = 5;

    localparam logic [WORD_W-1:0] SPACES = 32'h2020_2020;

    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_0 = 8'h30;

    // Two decimal digits: c2*10 + c3 carries a bias of '0' * 11.
    localparam logic [RAW_W-1:0] ADDR_BIAS = RAW_W'(11 * 48);

    localparam logic [OP_W-1:0] OP_NEW   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_START = 3'd2;
    localparam logic [OP_W-1:0] OP_EXEC  = 3'd3;
    localparam logic [OP_W-1:0] OP_CARD  = 3'd4;

    typedef enum logic [2:0] {
        K_DONE  = 3'd0,
        K_PRINT = 3'd1,
        K_HALT  = 3'd2,
        K_PAST  = 3'd3,
        K_WAIT  = 3'd4,
        K_IGN   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_RUN  = 3'b010,
        MODE_WAIT = 3'b100
    } mode_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [WORD_W-1:0] word_in;
    } cmd_beat_t;

    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] word_out;
        logic              last_of_run;
        logic [CNT_W-1:0]  counter_now;
    } res_beat_t;

    // Microprogram step addresses.
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t S_IDLE    = 5'd0;
    localparam step_t S_NEW     = 5'd1;
    localparam step_t S_LOAD    = 5'd2;
    localparam step_t S_LOAD2   = 5'd3;
    localparam step_t S_IGN     = 5'd4;
    localparam step_t S_START   = 5'd5;
    localparam step_t S_CARD    = 5'd6;
    localparam step_t S_CARD2   = 5'd7;
    localparam step_t S_CARD3   = 5'd8;
    localparam step_t S_CARD4   = 5'd9;
    localparam step_t S_CARDEND = 5'd10;
    localparam step_t S_EX      = 5'd11;
    localparam step_t S_EX1     = 5'd12;
    localparam step_t S_EX2     = 5'd13;
    localparam step_t S_EX3     = 5'd14;
    localparam step_t S_EX4     = 5'd15;
    localparam step_t S_HALT    = 5'd16;
    localparam step_t S_PAST    = 5'd17;
    localparam step_t S_LR      = 5'd18;
    localparam step_t S_LR2     = 5'd19;
    localparam step_t S_SR      = 5'd20;
    localparam step_t S_CR      = 5'd21;
    localparam step_t S_CR2     = 5'd22;
    localparam step_t S_BT      = 5'd23;
    localparam step_t S_BTBAD   = 5'd24;
    localparam step_t S_GD      = 5'd25;
    localparam step_t S_PD1     = 5'd26;
    localparam step_t S_PD2     = 5'd27;
    localparam step_t S_DONE    = 5'd28;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_IC   = 2'd1,
        RD_ADDR = 2'd2,
        RD_PD   = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_LP   = 2'd1,
        WR_ADDR = 2'd2,
        WR_CA   = 2'd3
    } wr_sel_t;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_GOTO     = 3'd1,
        J_COND     = 3'd2,
        J_LOOP     = 3'd3,
        J_DISPATCH = 3'd4,
        J_DECODE   = 3'd5
    } jmp_t;

    typedef enum logic [2:0] {
        C_LOAD_BAD = 3'd0,
        C_NOT_WAIT = 3'd1,
        C_NOT_RUN  = 3'd2,
        C_IC_PAST  = 3'd3,
        C_CC_FULL  = 3'd4,
        C_PD_MORE  = 3'd5
    } cond_t;

    typedef struct packed {
        rd_sel_t rd;
        wr_sel_t wr;
        logic    clr_job;
        logic    lp_inc;
        logic    ic_zero;
        logic    ic_inc;
        logic    ic_addr;
        logic    ic_past;
        logic    ld_ir;
        logic    ld_gr;
        logic    ld_flag;
        logic    ld_addr;
        logic    set_mode;
        mode_t   mode_val;
        logic    ca_load;
        logic    ca_inc;
        logic    cc_inc;
        logic    cc_clr;
        logic    pd_clr;
        logic    pd_inc;
        logic    emit;
        kind_t   kind;
        logic    last_pd;
        jmp_t    jmp;
        cond_t   cond;
        step_t   target;
    } cw_t;

    // Control store: one word per step.
    function automatic cw_t ucode(input step_t s);
        cw_t w;
        w          = '0;
        w.rd       = RD_NONE;
        w.wr       = WR_NONE;
        w.mode_val = MODE_IDLE;
        w.kind     = K_DONE;
        w.jmp      = J_GOTO;
        w.cond     = C_LOAD_BAD;
        w.target   = S_IDLE;
        case (s)
            S_IDLE:    w.jmp = J_DISPATCH;
            S_NEW:
            begin
                w.clr_job = 1'b1;
                w.emit    = 1'b1;
            end
            S_LOAD:
            begin
                w.jmp    = J_COND;
                w.cond   = C_LOAD_BAD;
                w.target = S_IGN;
            end
            S_LOAD2:
            begin
                w.wr     = WR_LP;
                w.lp_inc = 1'b1;
                w.emit   = 1'b1;
            end
            S_IGN:
            begin
                w.emit = 1'b1;
                w.kind = K_IGN;
            end
            S_START:
            begin
                w.ic_zero  = 1'b1;
                w.set_mode = 1'b1;
                w.mode_val = MODE_RUN;
                w.emit     = 1'b1;
            end
            S_CARD:
            begin
                w.jmp    = J_COND;
                w.cond   = C_NOT_WAIT;
                w.target = S_IGN;
            end
            S_CARD2:
            begin
                w.wr     = WR_CA;
                w.ca_inc = 1'b1;
                w.cc_inc = 1'b1;
                w.jmp    = J_NEXT;
            end
            S_CARD3:
            begin
                w.jmp    = J_COND;
                w.cond   = C_CC_FULL;
                w.target = S_CARDEND;
            end
            S_CARD4:
            begin
                w.emit = 1'b1;
                w.kind = K_WAIT;
            end
            S_CARDEND:
            begin
                w.cc_clr   = 1'b1;
                w.set_mode = 1'b1;
                w.mode_val = MODE_RUN;
                w.emit     = 1'b1;
            end
            S_EX:
            begin
                w.jmp    = J_COND;
                w.cond   = C_NOT_RUN;
                w.target = S_IGN;
            end
            S_EX1:
            begin
                w.jmp    = J_COND;
                w.cond   = C_IC_PAST;
                w.target = S_PAST;
            end
            S_EX2:
            begin
                w.rd  = RD_IC;
                w.jmp = J_NEXT;
            end
            S_EX3:
            begin
                w.ld_ir  = 1'b1;
                w.ic_inc = 1'b1;
                w.jmp    = J_NEXT;
            end
            S_EX4:
            begin
                w.ld_addr = 1'b1;
                w.pd_clr  = 1'b1;
                w.jmp     = J_DECODE;
            end
            S_HALT:
            begin
                w.set_mode = 1'b1;
                w.mode_val = MODE_IDLE;
                w.emit     = 1'b1;
                w.kind     = K_HALT;
            end
            S_PAST:
            begin
                w.set_mode = 1'b1;
                w.mode_val = MODE_IDLE;
                w.emit     = 1'b1;
                w.kind     = K_PAST;
            end
            S_LR:
            begin
                w.rd  = RD_ADDR;
                w.jmp = J_NEXT;
            end
            S_LR2:
            begin
                w.ld_gr = 1'b1;
                w.emit  = 1'b1;
            end
            S_SR:
            begin
                w.wr   = WR_ADDR;
                w.emit = 1'b1;
            end
            S_CR:
            begin
                w.rd  = RD_ADDR;
                w.jmp = J_NEXT;
            end
            S_CR2:
            begin
                w.ld_flag = 1'b1;
                w.emit    = 1'b1;
            end
            S_BT:
            begin
                w.ic_addr = 1'b1;
                w.emit    = 1'b1;
            end
            S_BTBAD:
            begin
                w.ic_past = 1'b1;
                w.emit    = 1'b1;
                w.kind    = K_IGN;
            end
            S_GD:
            begin
                w.ca_load  = 1'b1;
                w.cc_clr   = 1'b1;
                w.set_mode = 1'b1;
                w.mode_val = MODE_WAIT;
                w.emit     = 1'b1;
                w.kind     = K_WAIT;
            end
            S_PD1:
            begin
                w.rd  = RD_PD;
                w.jmp = J_NEXT;
            end
            S_PD2:
            begin
                w.emit    = 1'b1;
                w.kind    = K_PRINT;
                w.last_pd = 1'b1;
                w.pd_inc  = 1'b1;
                w.jmp     = J_LOOP;
                w.cond    = C_PD_MORE;
                w.target  = S_PD1;
            end
            S_DONE:    w.emit = 1'b1;
            default:   w.jmp = J_GOTO;
        endcase
        return w;
    endfunction

endpackage

### rtl/fcwm_ram.sv
`timescale 1ns / 1ps
module fcwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/four_char_word_machine_core_unit.sv
`timescale 1ns / 1ps
// Channel   Signals                    Beat contents
// cmd       cmd_valid, cmd_stall, cmd  opcode, word_in
// res       res_valid, res_stall, res  kind, word_out, last_of_run, counter_now
//
// Reset: control registers clear at once; per-word valid bits make the store read
// as four spaces with no clearing pass, and a new job clears them the same way.
// Stalls: cmd_stall is high off the idle step; a stalled result holds the emit step.
module four_char_word_machine_core_unit #(
    parameter int MEM_WORDS   = fcwm_pkg::MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = fcwm_pkg::BLOCK_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  fcwm_pkg::cmd_beat_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output fcwm_pkg::res_beat_t res
);

    import fcwm_pkg::*;

    localparam int AW    = $clog2(MEM_WORDS);
    localparam int SUM_W = CNT_W + 1;

    // Sequencer
    step_t upc_reg, upc_next;
    cw_t   cw;
    logic  fire;
    logic  cmd_accept;
    logic  cond_val;
    step_t dispatch_target;
    step_t decode_target;

    // Machine registers
    logic [CNT_W-1:0]  ic_reg, ic_next;
    logic [CNT_W-1:0]  lp_reg, lp_next;
    logic [CNT_W-1:0]  ca_reg, ca_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [WORD_W-1:0] gr_reg, gr_next;
    logic [WORD_W-1:0] ir_reg, ir_next;
    logic [WORD_W-1:0] word_reg;
    logic              flag_reg, flag_next;
    mode_t             mode_reg, mode_next;
    logic [CC_W-1:0]   cc_reg, cc_next;
    logic [CC_W-1:0]   pd_reg, pd_next;
    logic [MEM_WORDS-1:0] valid_reg, valid_next;

    // Word store access
    logic [SUM_W-1:0]  rd_full;
    logic              rd_en;
    logic              rd_ok;
    logic              rd_ok_reg;
    logic [WORD_W-1:0] ram_q;
    logic [WORD_W-1:0] rd_word;
    logic [CNT_W-1:0]  wr_full;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;

    // Instruction decode
    logic [7:0]       c0, c1, c2, c3;
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] raw_off;
    logic             addr_ok;

    // Result register
    logic      res_valid_reg;
    res_beat_t res_reg;
    logic      last_val;

    assign cw         = ucode(upc_reg);
    assign cmd_stall  = (upc_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    // Hold the step while its result cannot enter the output register.
    assign fire       = !cw.emit || !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Address field: two decimal digits, range-checked against the store.
    assign c0      = ir_reg[31:24];
    assign c1      = ir_reg[23:16];
    assign c2      = ir_reg[15:8];
    assign c3      = ir_reg[7:0];
    assign raw     = (RAW_W'(c2) << 3) + (RAW_W'(c2) << 1) + RAW_W'(c3);
    assign raw_off = raw - ADDR_BIAS;
    assign addr_ok = (raw >= ADDR_BIAS) && (raw < ADDR_BIAS + RAW_W'(MEM_WORDS));

    always_comb
    begin
        case (cmd.opcode)
            OP_NEW:   dispatch_target = S_NEW;
            OP_LOAD:  dispatch_target = S_LOAD;
            OP_START: dispatch_target = S_START;
            OP_EXEC:  dispatch_target = S_EX;
            OP_CARD:  dispatch_target = S_CARD;
            default:  dispatch_target = S_IGN;
        endcase
    end

    always_comb
    begin
        decode_target = S_DONE;
        if (c0 == CH_H)
        begin
            decode_target = S_HALT;
        end
        else if (c0 == CH_L && c1 == CH_R)
        begin
            decode_target = addr_ok ? S_LR : S_IGN;
        end
        else if (c0 == CH_S && c1 == CH_R)
        begin
            decode_target = addr_ok ? S_SR : S_IGN;
        end
        else if (c0 == CH_C && c1 == CH_R)
        begin
            decode_target = addr_ok ? S_CR : S_IGN;
        end
        else if (c0 == CH_B && c1 == CH_T)
        begin
            // An untaken branch is a plain done, whatever its address.
            if (flag_reg)
            begin
                decode_target = addr_ok ? S_BT : S_BTBAD;
            end
        end
        else if (c0 == CH_G && c1 == CH_D)
        begin
            decode_target = addr_ok ? S_GD : S_IGN;
        end
        else if (c0 == CH_P && c1 == CH_D)
        begin
            decode_target = addr_ok ? S_PD1 : S_IGN;
        end
    end

    always_comb
    begin
        case (cw.cond)
            C_LOAD_BAD: cond_val = (mode_reg == MODE_WAIT) ||
                                   (lp_reg >= CNT_W'(MEM_WORDS));
            C_NOT_WAIT: cond_val = (mode_reg != MODE_WAIT);
            C_NOT_RUN:  cond_val = (mode_reg != MODE_RUN);
            C_IC_PAST:  cond_val = (ic_reg >= CNT_W'(MEM_WORDS));
            C_CC_FULL:  cond_val = (cc_reg >= CC_W'(BLOCK_WORDS));
            C_PD_MORE:  cond_val = (pd_reg != CC_W'(BLOCK_WORDS - 1));
            default:    cond_val = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (fire)
        begin
            case (cw.jmp)
                J_NEXT:     upc_next = upc_reg + 1'b1;
                J_GOTO:     upc_next = cw.target;
                J_COND:     upc_next = cond_val ? cw.target : upc_reg + 1'b1;
                J_LOOP:     upc_next = cond_val ? cw.target : S_IDLE;
                J_DISPATCH: upc_next = cmd_accept ? dispatch_target : S_IDLE;
                J_DECODE:   upc_next = decode_target;
                default:    upc_next = S_IDLE;
            endcase
        end
    end

    // Read port: fetch at the counter, operand at the address, or a PD walk.
    always_comb
    begin
        case (cw.rd)
            RD_IC:   rd_full = SUM_W'(ic_reg);
            RD_ADDR: rd_full = SUM_W'(addr_reg);
            RD_PD:   rd_full = SUM_W'(addr_reg) + SUM_W'(pd_reg);
            default: rd_full = '0;
        endcase
    end

    assign rd_en   = fire && (cw.rd != RD_NONE);
    assign rd_ok   = (rd_full < SUM_W'(MEM_WORDS)) && valid_reg[rd_full[AW-1:0]];
    // Words never written and words past the end read as spaces.
    assign rd_word = rd_ok_reg ? ram_q : SPACES;

    always_comb
    begin
        case (cw.wr)
            WR_LP:   wr_full = lp_reg;
            WR_ADDR: wr_full = addr_reg;
            WR_CA:   wr_full = ca_reg;
            default: wr_full = '0;
        endcase
    end

    // Drop card words that fall past the end of the store.
    assign wr_en   = fire && (cw.wr != WR_NONE) && (wr_full < CNT_W'(MEM_WORDS));
    assign wr_data = (cw.wr == WR_ADDR) ? gr_reg : word_reg;

    fcwm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_full[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_full[AW-1:0]),
        .rd_data (ram_q)
    );

    // Datapath updates for the current step.
    always_comb
    begin
        ic_next    = ic_reg;
        lp_next    = lp_reg;
        ca_next    = ca_reg;
        addr_next  = addr_reg;
        gr_next    = gr_reg;
        ir_next    = ir_reg;
        flag_next  = flag_reg;
        mode_next  = mode_reg;
        cc_next    = cc_reg;
        pd_next    = pd_reg;
        valid_next = valid_reg;
        if (cw.clr_job)
        begin
            ic_next    = '0;
            lp_next    = '0;
            ca_next    = '0;
            gr_next    = SPACES;
            ir_next    = SPACES;
            flag_next  = 1'b0;
            mode_next  = MODE_IDLE;
            cc_next    = '0;
            valid_next = '0;
        end
        else
        begin
            if (cw.ic_zero)
            begin
                ic_next = '0;
            end
            if (cw.ic_inc)
            begin
                ic_next = ic_reg + 1'b1;
            end
            if (cw.ic_addr)
            begin
                ic_next = addr_reg;
            end
            if (cw.ic_past)
            begin
                ic_next = CNT_W'(MEM_WORDS);
            end
            if (cw.lp_inc)
            begin
                lp_next = lp_reg + 1'b1;
            end
            if (cw.ca_load)
            begin
                ca_next = addr_reg;
            end
            if (cw.ca_inc)
            begin
                ca_next = ca_reg + 1'b1;
            end
            if (cw.cc_inc)
            begin
                cc_next = cc_reg + 1'b1;
            end
            if (cw.cc_clr)
            begin
                cc_next = '0;
            end
            if (cw.pd_clr)
            begin
                pd_next = '0;
            end
            if (cw.pd_inc)
            begin
                pd_next = pd_reg + 1'b1;
            end
            if (cw.ld_addr)
            begin
                addr_next = raw_off[CNT_W-1:0];
            end
            if (cw.ld_ir)
            begin
                ir_next = rd_word;
            end
            if (cw.ld_gr)
            begin
                gr_next = rd_word;
            end
            if (cw.ld_flag)
            begin
                flag_next = (gr_reg == rd_word);
            end
            if (cw.set_mode)
            begin
                mode_next = cw.mode_val;
            end
            if (wr_en)
            begin
                valid_next[wr_full[AW-1:0]] = 1'b1;
            end
        end
    end

    assign last_val = cw.last_pd ? (pd_reg == CC_W'(BLOCK_WORDS - 1)) : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_IDLE;
            ic_reg        <= '0;
            lp_reg        <= '0;
            ca_reg        <= '0;
            addr_reg      <= '0;
            gr_reg        <= SPACES;
            ir_reg        <= SPACES;
            flag_reg      <= 1'b0;
            mode_reg      <= MODE_IDLE;
            cc_reg        <= '0;
            pd_reg        <= '0;
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (fire)
            begin
                ic_reg    <= ic_next;
                lp_reg    <= lp_next;
                ca_reg    <= ca_next;
                addr_reg  <= addr_next;
                gr_reg    <= gr_next;
                ir_reg    <= ir_next;
                flag_reg  <= flag_next;
                mode_reg  <= mode_next;
                cc_reg    <= cc_next;
                pd_reg    <= pd_next;
                valid_reg <= valid_next;
            end
            if (rd_en)
            begin
                rd_ok_reg <= rd_ok;
            end
            // Advance the result register: load on emit, drop once taken.
            if (fire && cw.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; counter_now is the counter after this step.
    always_ff @(posedge clk)
    begin
        if (fire && cw.emit && !cmd_accept)
        begin
            res_reg.kind        <= cw.kind;
            res_reg.word_out    <= (cw.kind == K_PRINT) ? rd_word : '0;
            res_reg.last_of_run <= last_val;
            res_reg.counter_now <= ic_next;
        end
        if (cmd_accept)
        begin
            word_reg <= cmd.word_in;
        end
    end

endmodule

### rtl/fcwm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcwm_checker #(
    parameter int MEM_WORDS = fcwm_pkg::MEM_WORDS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input logic                res_valid,
    input logic                res_stall,
    input fcwm_pkg::res_beat_t res
);

    import fcwm_pkg::*;

    `FCWM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res))
    `FCWM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)
    `FCWM_ASSERT_IMPLY(a_word_only_print, clk, rst_n, res_valid && res.kind != K_PRINT, res.word_out == '0)
    `FCWM_ASSERT_IMPLY(a_busy_mid_run, clk, rst_n, res_valid && !res.last_of_run, cmd_stall)
    `FCWM_ASSERT_IMPLY(a_counter_range, clk, rst_n, res_valid, res.counter_now <= 7'(MEM_WORDS))

endmodule

bind four_char_word_machine_core_unit fcwm_checker #(
    .MEM_WORDS (MEM_WORDS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import fcwm_pkg::*;

    localparam int MEM     = MEM_WORDS_DEF;
    localparam int BLOCK   = BLOCK_WORDS_DEF;
    localparam int N_ITEMS = 170;
    localparam int TAIL    = 40;
    localparam int LIMIT   = 600000;

    // One queued command beat plus a flag that holds it back until every
    // earlier result beat has been checked.
    typedef struct packed {
        logic      drain;
        cmd_beat_t beat;
    } cmd_slot_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_beat_t cmd       = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_beat_t res;

    cmd_slot_t cmd_backlog[$];
    res_beat_t expected_res[$];

    // Shadow copy of the machine, advanced once per accepted command beat.
    logic [31:0] shadow_store[MEM];
    logic [6:0]  pc;
    logic [31:0] acc;
    logic [31:0] ireg;
    logic        toggle;
    logic [6:0]  load_ptr;
    mode_t       run_state;
    logic [6:0]  card_ptr;
    logic [3:0]  card_cnt;

    int  cmds_taken = 0;
    int  beats_seen = 0;
    int  n_bad      = 0;
    int  cycles     = 0;
    int  idle_left  = 0;
    int  stall_left = 0;
    int  jobs       = 0;
    bit  steady;

    always #5 clk = ~clk;

    four_char_word_machine_core_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Every fourth stretch of 25 commands runs with no idling on either side.
    assign steady = ((cmds_taken / 25) % 4) == 3;

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void clear_machine();
        for (int i = 0; i < MEM; i++)
            shadow_store[i] = SPACES;
        pc        = '0;
        acc       = SPACES;
        ireg      = SPACES;
        toggle    = 1'b0;
        load_ptr  = '0;
        run_state = MODE_IDLE;
        card_ptr  = '0;
        card_cnt  = '0;
    endfunction

    function automatic res_beat_t make_beat(kind_t k, logic [31:0] w);
        res_beat_t b;
        b.kind        = k;
        b.word_out    = w;
        b.last_of_run = 1'b0;
        b.counter_now = pc;
        return b;
    endfunction

    // Advance the shadow machine by one command beat and queue the result
    // beats it must produce, the final one marked as last.
    function automatic void advance_machine(cmd_beat_t b);
        res_beat_t   outs[BLOCK];
        kind_t       k;
        int          n;
        int          addr;
        bit          ok;
        logic [7:0]  c0;
        logic [7:0]  c1;
        k = K_DONE;
        n = 1;
        case (b.opcode)
            OP_NEW: clear_machine();
            OP_LOAD:
            begin
                if (run_state == MODE_WAIT || load_ptr >= MEM)
                    k = K_IGN;
                else
                begin
                    shadow_store[load_ptr] = b.word_in;
                    load_ptr++;
                end
            end
            OP_START:
            begin
                pc        = '0;
                run_state = MODE_RUN;
            end
            OP_EXEC:
            begin
                if (run_state != MODE_RUN)
                    k = K_IGN;
                else if (pc >= MEM)
                begin
                    run_state = MODE_IDLE;
                    k         = K_PAST;
                end
                else
                begin
                    ireg = shadow_store[pc];
                    pc++;
                    c0   = ireg[31:24];
                    c1   = ireg[23:16];
                    addr = (int'(ireg[15:8]) - int'(CH_0)) * 10
                         + (int'(ireg[7:0]) - int'(CH_0));
                    ok   = addr >= 0 && addr < MEM;
                    if (c0 == CH_H)
                    begin
                        run_state = MODE_IDLE;
                        k         = K_HALT;
                    end
                    else if (c0 == CH_L && c1 == CH_R)
                    begin
                        if (ok) acc = shadow_store[addr];
                        else    k = K_IGN;
                    end
                    else if (c0 == CH_S && c1 == CH_R)
                    begin
                        if (ok) shadow_store[addr] = acc;
                        else    k = K_IGN;
                    end
                    else if (c0 == CH_C && c1 == CH_R)
                    begin
                        if (ok) toggle = (acc == shadow_store[addr]);
                        else    k = K_IGN;
                    end
                    else if (c0 == CH_B && c1 == CH_T)
                    begin
                        // An untaken branch never looks at its address.
                        if (toggle && ok)
                            pc = addr[6:0];
                        else if (toggle)
                        begin
                            pc = 7'(MEM);
                            k  = K_IGN;
                        end
                    end
                    else if (c0 == CH_G && c1 == CH_D)
                    begin
                        if (ok)
                        begin
                            card_ptr  = addr[6:0];
                            card_cnt  = '0;
                            run_state = MODE_WAIT;
                            k         = K_WAIT;
                        end
                        else
                            k = K_IGN;
                    end
                    else if (c0 == CH_P && c1 == CH_D)
                    begin
                        if (ok)
                        begin
                            // Words past the store end print as spaces.
                            for (int i = 0; i < BLOCK; i++)
                                outs[i] = make_beat(K_PRINT, (addr + i < MEM) ?
                                                    shadow_store[addr + i] : SPACES);
                            n = BLOCK;
                        end
                        else
                            k = K_IGN;
                    end
                end
            end
            OP_CARD:
            begin
                if (run_state != MODE_WAIT)
                    k = K_IGN;
                else
                begin
                    // Drop card words that fall past the store end.
                    if (card_ptr < MEM)
                        shadow_store[card_ptr] = b.word_in;
                    card_ptr++;
                    card_cnt++;
                    if (card_cnt >= BLOCK)
                    begin
                        card_cnt  = '0;
                        run_state = MODE_RUN;
                    end
                    else
                        k = K_WAIT;
                end
            end
            default: k = K_IGN;
        endcase
        if (n == 1)
            outs[0] = make_beat(k, '0);
        for (int i = 0; i < n; i++)
        begin
            outs[i].last_of_run = (i == n - 1);
            expected_res.push_back(outs[i]);
        end
    endfunction

    function automatic void log_mismatch(string what, res_beat_t want, res_beat_t got);
        n_bad++;
        if (n_bad <= 10)
            $display("%0t %s, result beat %0d: ", $time, what, beats_seen,
                     "want kind %0d word %h last %b pc %0d, ", want.kind, want.word_out,
                     want.last_of_run, want.counter_now,
                     "got kind %0d word %h last %b pc %0d", got.kind, got.word_out,
                     got.last_of_run, got.counter_now);
    endfunction

    function automatic void queue_cmd(logic [OP_W-1:0] op, logic [31:0] w, bit drain);
        cmd_slot_t s;
        s.drain        = drain;
        s.beat.opcode  = op;
        s.beat.word_in = w;
        cmd_backlog.push_back(s);
    endfunction

    function automatic logic [31:0] instr_word(logic [7:0] c0, logic [7:0] c1, int a);
        return {c0, c1, CH_0 + 8'(a / 10), CH_0 + 8'(a % 10)};
    endfunction

    // Random instruction: data-area addresses mostly, the store tail at times,
    // branches back into the program, and some malformed words.
    function automatic logic [31:0] pick_instr(int plen);
        int         r;
        int         a;
        logic [7:0] c0;
        logic [7:0] c1;
        r = $urandom_range(0, 99);
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(90, 99) : $urandom_range(40, 59);
        c0 = CH_L;
        c1 = CH_R;
        if (r < 15)
            c0 = CH_L;
        else if (r < 30)
            c0 = CH_S;
        else if (r < 45)
            c0 = CH_C;
        else if (r < 58)
        begin
            c0 = CH_B;
            c1 = CH_T;
            a  = ($urandom_range(0, 2) == 0) ? $urandom_range(90, 99)
                                             : $urandom_range(0, plen - 1);
        end
        else if (r < 70)
        begin
            c0 = CH_G;
            c1 = CH_D;
        end
        else if (r < 82)
        begin
            c0 = CH_P;
            c1 = CH_D;
        end
        else if (r < 88)
            return {CH_H, 24'($urandom())};
        else if (r < 93)
            return $urandom();
        else
        begin
            // Random address bytes, seldom both digits: mostly out of range.
            case ($urandom_range(0, 5))
                0: c0 = CH_L;
                1: c0 = CH_S;
                2: c0 = CH_C;
                3: begin c0 = CH_B; c1 = CH_T; end
                4: begin c0 = CH_G; c1 = CH_D; end
                default: begin c0 = CH_P; c1 = CH_D; end
            endcase
            return {c0, c1, 8'($urandom()), 8'($urandom())};
        end
        return instr_word(c0, c1, a);
    endfunction

    // Driver: present the next queued command beat, hold it while stalled,
    // idle between beats, and feed every accepted beat to the shadow machine.
    always @(posedge clk)
    begin : drive
        cmd_slot_t slot;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                advance_machine(cmd);
                cmds_taken++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain && expected_res.size() != 0))
                begin
                    slot      = cmd_backlog.pop_front();
                    cmd       <= slot.beat;
                    cmd_valid <= 1'b1;
                    idle_left = gap_len();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result beat against the oldest expected
    // one, and stall the result channel at random.
    always @(posedge clk)
    begin : watch
        res_beat_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_res.size() == 0)
                    log_mismatch("unexpected beat", '0, res);
                else
                begin
                    want = expected_res.pop_front();
                    if (res.kind !== want.kind || res.word_out !== want.word_out ||
                        res.last_of_run !== want.last_of_run ||
                        res.counter_now !== want.counter_now)
                        log_mismatch("mismatch", want, res);
                end
                beats_seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall  <= 1'b0;
                stall_left = gap_len();
            end
        end
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result beats still expected",
                     cycles, expected_res.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] prog[16];
        logic [31:0] w;
        int          plen;
        int          guess;
        int          burst;
        clear_machine();

        // Directed: unknown opcodes, commands out of their mode, then a program
        // that collects a card at the store tail, prints across the end, sets
        // the flag and takes a branch to a bad address, then runs off the end.
        queue_cmd(3'd7, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(3'd5, 32'h0000_0000, 1'b0);
        queue_cmd(OP_EXEC, $urandom(), 1'b0);
        queue_cmd(OP_CARD, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_NEW, $urandom(), 1'b0);
        queue_cmd(OP_LOAD, instr_word(CH_G, CH_D, 95), 1'b0);
        queue_cmd(OP_LOAD, instr_word(CH_P, CH_D, 95), 1'b0);
        queue_cmd(OP_LOAD, instr_word(CH_C, CH_R, 50), 1'b0);
        // '/' as tens digit gives address -1
        queue_cmd(OP_LOAD, {CH_B, CH_T, 8'h2F, 8'h39}, 1'b0);
        queue_cmd(OP_START, $urandom(), 1'b0);
        queue_cmd(OP_EXEC, $urandom(), 1'b0);
        queue_cmd(OP_CARD, 32'h0000_0000, 1'b0);
        queue_cmd(OP_CARD, 32'hFFFF_FFFF, 1'b0);
        repeat (BLOCK - 2) queue_cmd(OP_CARD, $urandom(), 1'b0);
        repeat (4) queue_cmd(OP_EXEC, $urandom(), 1'b0);

        // Random jobs: load a short program, start it, step it, and follow
        // each GD that straight-line flow predicts with a card. Branches make
        // that guess wrong at times, which supplies stray card words.
        while (cmd_backlog.size() < N_ITEMS)
        begin
            queue_cmd(OP_NEW, $urandom(), jobs % 3 == 0);
            if (jobs == 2)
            begin
                // Fill the store and push past its end.
                repeat (MEM + 3) queue_cmd(OP_LOAD, $urandom(), 1'b0);
                queue_cmd(OP_START, $urandom(), 1'b0);
                repeat (4) queue_cmd(OP_EXEC, $urandom(), 1'b0);
            end
            else
            begin
                plen = $urandom_range(3, 12);
                for (int i = 0; i < plen; i++)
                begin
                    prog[i] = pick_instr(plen);
                    queue_cmd(OP_LOAD, prog[i], 1'b0);
                end
                queue_cmd(OP_START, $urandom(), 1'b0);
                guess = 0;
                repeat (plen + $urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 9) == 0)
                        queue_cmd(3'($urandom_range(0, 7)), $urandom(), 1'b0);
                    w = (guess < plen) ? prog[guess] : SPACES;
                    queue_cmd(OP_EXEC, $urandom(), 1'b0);
                    if (w[31:24] == CH_G && w[23:16] == CH_D)
                    begin
                        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : BLOCK;
                        repeat (burst) queue_cmd(OP_CARD, $urandom(), 1'b0);
                    end
                    guess++;
                end
            end
            jobs++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait for every beat to go in and every result to come back,
        // then let the block settle to catch stray results.
        while (cmd_backlog.size() != 0 || cmd_valid || expected_res.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("ran %0d command beats over %0d random jobs (one filling the store)",
                 cmds_taken, jobs);
        $display("checked %0d result beats, %0d mismatched", beats_seen, n_bad);
        if (n_bad == 0 && expected_res.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

### four_char_word_machine_core_unit.f
+incdir+rtl
rtl/fcwm_pkg.sv
rtl/fcwm_ram.sv
rtl/four_char_word_machine_core_unit.sv
rtl/fcwm_checker.sv
tb/tb.sv
